// ===== rtl/detection_row_decode_assert.svh =====
// assertion macros for the detection row decoder
`ifndef DETECTION_ROW_DECODE_ASSERT_SVH
`define DETECTION_ROW_DECODE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define DRD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define DRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/drd_pkg.sv =====
// types, constants and per-axis arithmetic for the detection row decoder
`timescale 1ns / 1ps

package drd_pkg;

    localparam int C_MAX_CLASSES = 64;
    localparam int C_FRAC        = 16;

    localparam int C_VALUE_W = 27;
    localparam int C_CLASS_W = $clog2(C_MAX_CLASSES);
    localparam int C_COUNT_W = 7;
    localparam int C_CONF_W  = 17;
    localparam int C_PAD_W   = 10;
    localparam int C_SCALE_W = 24;
    localparam int C_DIM_W   = 13;
    localparam int C_SIZE_W  = 15;
    localparam int C_IDX_W   = 3;

    localparam int C_IN_TDATA_W  = 32;
    localparam int C_OUT_TDATA_W = 80;

    // row element positions
    localparam logic [C_COUNT_W-1:0] C_POS_CX    = 7'd0;
    localparam logic [C_COUNT_W-1:0] C_POS_CY    = 7'd1;
    localparam logic [C_COUNT_W-1:0] C_POS_W     = 7'd2;
    localparam logic [C_COUNT_W-1:0] C_POS_H     = 7'd3;
    localparam logic [C_COUNT_W-1:0] C_POS_SCORE = 7'd4;
    localparam logic [C_COUNT_W-1:0] C_POS_SAT   = 7'd127;
    localparam logic [C_COUNT_W-1:0] C_POS_END   = C_COUNT_W'(4 + C_MAX_CLASSES);

    // register indexes
    localparam logic [C_IDX_W-1:0] C_REG_THRESH = 3'd0;
    localparam logic [C_IDX_W-1:0] C_REG_PAD_EN = 3'd1;
    localparam logic [C_IDX_W-1:0] C_REG_PAD_X  = 3'd2;
    localparam logic [C_IDX_W-1:0] C_REG_PAD_Y  = 3'd3;
    localparam logic [C_IDX_W-1:0] C_REG_SCL_X  = 3'd4;
    localparam logic [C_IDX_W-1:0] C_REG_SCL_Y  = 3'd5;
    localparam logic [C_IDX_W-1:0] C_REG_IMG_W  = 3'd6;
    localparam logic [C_IDX_W-1:0] C_REG_IMG_H  = 3'd7;

    localparam logic [C_CONF_W-1:0] C_CONF_MAX = 17'd65536;

    // per-axis datapath widths
    localparam int C_CTR_W   = C_VALUE_W + 1;
    localparam int C_DIFF_W  = C_CTR_W + 2;
    localparam int C_EP_W    = C_DIFF_W + C_SCALE_W + 1;
    localparam int C_LP_W    = C_VALUE_W + C_SCALE_W + 1;
    localparam int C_EDGE_SH = C_FRAC + 17;
    localparam int C_LEN_SH  = C_FRAC + 16;
    localparam int C_ET_W    = C_EP_W - C_EDGE_SH;
    localparam int C_LT_W    = C_LP_W - C_LEN_SH;
    localparam int C_LIM_W   = C_ET_W + 1;

    localparam logic signed [C_EP_W-1:0] C_EDGE_BIAS = C_EP_W'((64'd1 << C_EDGE_SH) - 64'd1);
    localparam logic signed [C_LP_W-1:0] C_LEN_BIAS  = C_LP_W'((64'd1 << C_LEN_SH) - 64'd1);

    localparam logic signed [C_LIM_W-1:0] C_SIZE_HI = C_LIM_W'(16383);
    localparam logic signed [C_LIM_W-1:0] C_SIZE_LO = -C_LIM_W'(16383);
    localparam logic signed [C_ET_W-1:0]  C_POS_HI  = C_ET_W'(8191);

    typedef struct packed {
        logic signed [C_DIFF_W-1:0]  diff;
        logic signed [C_VALUE_W-1:0] size;
    } t_axis_in;

    typedef struct packed {
        logic signed [C_EP_W-1:0] edge_p;
        logic signed [C_LP_W-1:0] len_p;
    } t_axis_prod;

    typedef struct packed {
        logic signed [C_ET_W-1:0] edge_t;
        logic signed [C_LT_W-1:0] len_t;
    } t_axis_trunc;

    typedef struct packed {
        logic [C_DIM_W-1:0]         pos;
        logic signed [C_SIZE_W-1:0] len;
    } t_axis_out;

    typedef struct packed {
        logic [C_CLASS_W-1:0] class_id;
        logic [C_CONF_W-1:0]  confidence;
    } t_score;

    // divide by a power of two, rounding toward zero
    function automatic t_axis_trunc axis_trunc(input t_axis_prod p);
        logic signed [C_EP_W-1:0] e_adj;
        logic signed [C_LP_W-1:0] l_adj;
        e_adj = p.edge_p + (p.edge_p[C_EP_W-1] ? C_EDGE_BIAS : '0);
        l_adj = p.len_p + (p.len_p[C_LP_W-1] ? C_LEN_BIAS : '0);
        axis_trunc.edge_t = C_ET_W'(e_adj >>> C_EDGE_SH);
        axis_trunc.len_t  = C_LT_W'(l_adj >>> C_LEN_SH);
    endfunction

    // clamp edge at zero, limit size to the image, saturate both
    function automatic t_axis_out axis_clamp(input t_axis_trunc t,
                                             input logic [C_DIM_W-1:0] bound);
        logic signed [C_ET_W-1:0]  ec;
        logic signed [C_LIM_W-1:0] lim;
        logic signed [C_LIM_W-1:0] lx;
        logic signed [C_LIM_W-1:0] l2;
        ec  = t.edge_t[C_ET_W-1] ? '0 : t.edge_t;
        lim = $signed({{(C_LIM_W-C_DIM_W){1'b0}}, bound}) - C_LIM_W'(ec);
        lx  = C_LIM_W'(t.len_t);
        l2  = (lx > lim) ? lim : lx;
        if (l2 > C_SIZE_HI) begin
            axis_clamp.len = C_SIZE_W'(C_SIZE_HI);
        end else if (l2 < C_SIZE_LO) begin
            axis_clamp.len = C_SIZE_W'(C_SIZE_LO);
        end else begin
            axis_clamp.len = C_SIZE_W'(l2);
        end
        axis_clamp.pos = (ec > C_POS_HI) ? C_DIM_W'(C_POS_HI) : C_DIM_W'(ec);
    endfunction

endpackage

// ===== rtl/detection_row_decode.sv =====
// detection row decoder: arg-max over class scores and box rescaling
//
//  channel   | dir | beat contents
//  ----------+-----+------------------------------------------------------------
//  s_axis    | in  | one row element (value) and tlast at the final element
//  m_axis    | out | one detection: class, confidence, left, top, width, height
//  cfg       | in  | register index and write data, always ready
//
//  one element accepted per cycle while a held result does not stall intake; once its
//  last element is accepted, a detection passes the four register stages b to e behind the input register
//  reset is synchronous and active low; no clearing pass is needed
//  each stage moves on when the one after it is empty or moving, so a held
//  result stalls intake only once every stage is full
`timescale 1ns / 1ps
`include "detection_row_decode_assert.svh"

module detection_row_decode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [26:0] value, [31:27] zero
    input  logic [drd_pkg::C_IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [5:0] class_id, [22:6] confidence, [35:23] box_left, [48:36] box_top,
    // [63:49] box_width, [78:64] box_height, [79] zero
    output logic [drd_pkg::C_OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [drd_pkg::C_IDX_W-1:0]         i_cfg_index,
    input  logic [drd_pkg::C_SCALE_W-1:0]       i_cfg_data
);
    import drd_pkg::*;

    // configuration
    logic [C_CONF_W-1:0]  r_thresh;
    logic                 r_pad_en;
    logic [C_PAD_W-1:0]   r_pad_x;
    logic [C_PAD_W-1:0]   r_pad_y;
    logic [C_SCALE_W-1:0] r_scale_x;
    logic [C_SCALE_W-1:0] r_scale_y;
    logic [C_DIM_W-1:0]   r_img_w;
    logic [C_DIM_W-1:0]   r_img_h;

    // row state
    logic [C_COUNT_W-1:0]        r_count, n_count;
    logic signed [C_VALUE_W-1:0] r_cx, n_cx;
    logic signed [C_VALUE_W-1:0] r_cy, n_cy;
    logic signed [C_VALUE_W-1:0] r_w, n_w;
    logic signed [C_VALUE_W-1:0] r_h, n_h;
    logic signed [C_VALUE_W-1:0] r_best, n_best;
    logic [C_CLASS_W-1:0]        r_idx, n_idx;

    // pipeline stages
    logic                        r_a_vld;
    logic signed [C_VALUE_W-1:0] r_a_value;
    logic                        r_a_last;
    logic                        r_b_vld;
    t_score                      r_b_score;
    t_axis_in                    r_b_x, r_b_y;
    logic                        r_c_vld;
    t_score                      r_c_score;
    t_axis_prod                  r_c_x, r_c_y;
    logic                        r_d_vld;
    t_score                      r_d_score;
    t_axis_trunc                 r_d_x, r_d_y;
    logic                        r_e_vld;
    t_score                      r_e_score;
    t_axis_out                   r_e_x, r_e_y;

    logic en_a, en_b, en_c, en_d, en_e;
    logic take_b;
    logic fire;
    logic [C_CONF_W-1:0] conf;
    logic signed [C_CTR_W-1:0] ctr_x, ctr_y;
    t_axis_in ax_x, ax_y;

    assign en_e = !r_e_vld || m_axis_tready;
    assign en_d = !r_d_vld || en_e;
    assign en_c = !r_c_vld || en_d;
    assign en_b = !r_b_vld || en_c;
    assign en_a = !r_a_vld || en_b;
    assign take_b = r_a_vld && en_b;

    assign s_axis_tready = en_a;
    assign o_cfg_ready   = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= 17'd32768;
            r_pad_en  <= 1'b1;
            r_pad_x   <= '0;
            r_pad_y   <= '0;
            r_scale_x <= 24'd65536;
            r_scale_y <= 24'd65536;
            r_img_w   <= 13'd640;
            r_img_h   <= 13'd640;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                C_REG_THRESH: r_thresh  <= i_cfg_data[C_CONF_W-1:0];
                C_REG_PAD_EN: r_pad_en  <= i_cfg_data[0];
                C_REG_PAD_X:  r_pad_x   <= i_cfg_data[C_PAD_W-1:0];
                C_REG_PAD_Y:  r_pad_y   <= i_cfg_data[C_PAD_W-1:0];
                C_REG_SCL_X:  r_scale_x <= i_cfg_data;
                C_REG_SCL_Y:  r_scale_y <= i_cfg_data;
                C_REG_IMG_W:  r_img_w   <= i_cfg_data[C_DIM_W-1:0];
                C_REG_IMG_H:  r_img_h   <= i_cfg_data[C_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // row state update
    always_comb begin
        n_count = r_count;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_w     = r_w;
        n_h     = r_h;
        n_best  = r_best;
        n_idx   = r_idx;
        if (r_count != C_POS_SAT) begin
            n_count = r_count + 7'd1;
            case (r_count)
                C_POS_CX: n_cx = r_a_value;
                C_POS_CY: n_cy = r_a_value;
                C_POS_W:  n_w  = r_a_value;
                C_POS_H:  n_h  = r_a_value;
                default: begin
                    if (r_count < C_POS_END &&
                        (r_count == C_POS_SCORE || r_a_value > r_best)) begin
                        n_best = r_a_value;
                        n_idx  = C_CLASS_W'(r_count - C_POS_SCORE);
                    end
                end
            endcase
        end
        if (r_a_last) begin
            n_count = '0;
        end
    end

    assign fire = (r_count >= C_POS_SCORE) &&
                  ($signed({n_best[C_VALUE_W-1], n_best}) >
                   $signed({{(C_VALUE_W+1-C_CONF_W){1'b0}}, r_thresh}));
    assign conf = (n_best > $signed({{(C_VALUE_W-C_CONF_W){1'b0}}, C_CONF_MAX}))
                  ? C_CONF_MAX : n_best[C_CONF_W-1:0];

    assign ctr_x = C_CTR_W'(r_cx) - (r_pad_en ? C_CTR_W'({r_pad_x, {C_FRAC{1'b0}}}) : '0);
    assign ctr_y = C_CTR_W'(r_cy) - (r_pad_en ? C_CTR_W'({r_pad_y, {C_FRAC{1'b0}}}) : '0);
    assign ax_x.diff = C_DIFF_W'($signed({ctr_x, 1'b0})) - C_DIFF_W'(r_w);
    assign ax_x.size = r_w;
    assign ax_y.diff = C_DIFF_W'($signed({ctr_y, 1'b0})) - C_DIFF_W'(r_h);
    assign ax_y.size = r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_best  <= '0;
            r_idx   <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_vld <= s_axis_tvalid;
            end
            if (take_b) begin
                r_count <= n_count;
                r_cx    <= n_cx;
                r_cy    <= n_cy;
                r_w     <= n_w;
                r_h     <= n_h;
                r_best  <= n_best;
                r_idx   <= n_idx;
            end
            if (en_b) begin
                r_b_vld <= r_a_vld && r_a_last && fire;
            end
            if (en_c) begin
                r_c_vld <= r_b_vld;
            end
            if (en_d) begin
                r_d_vld <= r_c_vld;
            end
            if (en_e) begin
                r_e_vld <= r_d_vld;
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_value <= s_axis_tdata[C_VALUE_W-1:0];
            r_a_last  <= s_axis_tlast;
        end
        if (en_b) begin
            r_b_score.class_id   <= n_idx;
            r_b_score.confidence <= conf;
            r_b_x                <= ax_x;
            r_b_y                <= ax_y;
        end
        if (en_c) begin
            r_c_score    <= r_b_score;
            r_c_x.edge_p <= C_EP_W'(r_b_x.diff * $signed({1'b0, r_scale_x}));
            r_c_x.len_p  <= C_LP_W'(r_b_x.size * $signed({1'b0, r_scale_x}));
            r_c_y.edge_p <= C_EP_W'(r_b_y.diff * $signed({1'b0, r_scale_y}));
            r_c_y.len_p  <= C_LP_W'(r_b_y.size * $signed({1'b0, r_scale_y}));
        end
        if (en_d) begin
            r_d_score <= r_c_score;
            r_d_x     <= axis_trunc(r_c_x);
            r_d_y     <= axis_trunc(r_c_y);
        end
        if (en_e) begin
            r_e_score <= r_d_score;
            r_e_x     <= axis_clamp(r_d_x, r_img_w);
            r_e_y     <= axis_clamp(r_d_y, r_img_h);
        end
    end

    assign m_axis_tvalid = r_e_vld;
    assign m_axis_tdata  = {1'b0, r_e_y.len, r_e_x.len, r_e_y.pos, r_e_x.pos,
                            r_e_score.confidence, r_e_score.class_id};

    `DRD_ASSERT_NEXT(a_count_clear, take_b && r_a_last, r_count == '0, "row count not cleared")
    `DRD_ASSERT_IMPL(a_conf_nonzero, r_b_vld, r_b_score.confidence != '0, "zero confidence")
    `DRD_ASSERT_IMPL(a_width_bound, r_e_vld, $signed(r_e_x.len) <= $signed({2'b00, r_img_w}), "width over image")
    `DRD_ASSERT_NEXT(a_stage_hold, r_d_vld && !en_e, r_d_vld, "stalled result lost")

endmodule
